// ----- src/abfdu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abfdu_pkg: shared types and constants
// Beat payloads, control groups, state codes and widths for the
// absorbing-boundary field damper.
// ----------------------------------------------------------------------------
`default_nettype none

package abfdu_pkg;

   localparam int GRID_DEFAULT = 256;
   localparam int NUM_LANES    = 6;
   localparam int NUM_SLABS    = 6;
   localparam int SLAB_IDX_W   = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_W        = 9;
   localparam int COORD_W      = 8;
   localparam int CALC_W       = 14;
   localparam int DIV_W        = 21;
   localparam int QUOT_W       = 32;
   localparam int DIV_CNT_W    = 6;
   localparam int MAG_W        = 32;
   localparam int TERM_W       = 64;
   localparam int PAIR_W       = 65;
   localparam int SUM_W        = 67;
   localparam int ENERGY_W     = 63;

   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_LOW_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_HIGH_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_LOW_Y  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_HIGH_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_LOW_Z  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP_HIGH_Z = 3'd5;

   localparam logic [SLAB_IDX_W-1:0] SLAB_X_LOW  = 3'd0;
   localparam logic [SLAB_IDX_W-1:0] SLAB_X_HIGH = 3'd1;
   localparam logic [SLAB_IDX_W-1:0] SLAB_Y_HIGH = 3'd2;
   localparam logic [SLAB_IDX_W-1:0] SLAB_Y_LOW  = 3'd3;
   localparam logic [SLAB_IDX_W-1:0] SLAB_Z_HIGH = 3'd4;
   localparam logic [SLAB_IDX_W-1:0] SLAB_Z_LOW  = 3'd5;
   localparam logic [SLAB_IDX_W-1:0] SLAB_END    = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] node_x;
      logic [COORD_W-1:0] node_y;
      logic [COORD_W-1:0] node_z;
      logic signed [31:0] ex_in;
      logic signed [31:0] ey_in;
      logic signed [31:0] ez_in;
      logic signed [31:0] bx_in;
      logic signed [31:0] by_in;
      logic signed [31:0] bz_in;
      logic               clear_energy;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0]  ex_out;
      logic signed [31:0]  ey_out;
      logic signed [31:0]  ez_out;
      logic signed [31:0]  bx_out;
      logic signed [31:0]  by_out;
      logic signed [31:0]  bz_out;
      logic [ENERGY_W-1:0] energy_removed;
      logic                energy_saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic sq_en;
      logic mul_en;
      logic upd_en;
   } lane_ctrl_type;

   typedef struct packed {
      logic clear;
      logic pair_en;
      logic sum_en;
      logic acc_en;
   } merge_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEL,
      ST_DIV,
      ST_SQ,
      ST_MUL,
      ST_UPD,
      ST_SUM,
      ST_SUM2,
      ST_ACC,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- src/abfdu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abfdu_div: damping factor divider
// Restoring divider, one quotient bit a cycle, for a fraction num/den
// with num below den; gives the Q0.32 quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module abfdu_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [abfdu_pkg::DIV_W-1:0]   num,
   input  wire logic [abfdu_pkg::DIV_W-1:0]   den,
   output logic                               busy,
   output logic [abfdu_pkg::QUOT_W-1:0]       quot
);

   logic [abfdu_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [abfdu_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [abfdu_pkg::DIV_W-1:0]     den_ff, den_in;
   logic [abfdu_pkg::QUOT_W-1:0]    quot_ff, quot_in;
   logic [abfdu_pkg::DIV_W:0]       rem2;
   logic                            ge;

   always_comb begin
      rem2    = {rem_ff, 1'b0};
      ge      = rem2 >= {1'b0, den_ff};
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      if (start) begin
         cnt_in  = abfdu_pkg::DIV_CNT_W'(abfdu_pkg::QUOT_W);
         rem_in  = num;
         den_in  = den;
         quot_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         rem_in  = ge ? abfdu_pkg::DIV_W'(rem2 - {1'b0, den_ff})
                      : rem2[abfdu_pkg::DIV_W-1:0];
         quot_in = {quot_ff[abfdu_pkg::QUOT_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy = cnt_ff != '0;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ----- src/abfdu_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abfdu_lane: one field component
// Holds sign and magnitude of one component, scales it by the slab
// factor and forms its energy term for the slab.
// ----------------------------------------------------------------------------
`default_nettype none

module abfdu_lane (
   input  wire logic                            clock,
   input  wire abfdu_pkg::lane_ctrl_type        ctrl,
   input  wire logic signed [31:0]              value_in,
   input  wire logic [abfdu_pkg::QUOT_W-1:0]    fq,
   input  wire logic [abfdu_pkg::QUOT_W-1:0]    g,
   output logic [abfdu_pkg::TERM_W-1:0]         term,
   output logic signed [31:0]                   value_out
);

   logic                           neg_ff;
   logic [abfdu_pkg::MAG_W-1:0]    mag_ff;
   logic [63:0]                    sq_ff;
   logic [63:0]                    a_ff;
   logic [31:0]                    bh_ff;
   logic [abfdu_pkg::MAG_W-1:0]    mfq_ff;
   logic [abfdu_pkg::TERM_W-1:0]   term_ff;
   logic [63:0]                    b_full;
   logic [63:0]                    mfq_full;
   logic [64:0]                    a_sum;

   always_comb begin
      b_full   = 64'(sq_ff[31:0]) * 64'(g);
      mfq_full = 64'(mag_ff) * 64'(fq);
      a_sum    = {1'b0, a_ff} + 65'(bh_ff);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         neg_ff <= value_in[31];
         mag_ff <= value_in[31] ? 32'(~value_in + 1'b1) : 32'(value_in);
      end else if (ctrl.upd_en) begin
         mag_ff <= mfq_ff;
      end
      if (ctrl.sq_en) begin
         sq_ff <= 64'(mag_ff) * 64'(mag_ff);
      end
      if (ctrl.mul_en) begin
         a_ff   <= 64'(sq_ff[63:32]) * 64'(g);
         bh_ff  <= b_full[63:32];
         mfq_ff <= mfq_full[63:32];
      end
      if (ctrl.upd_en) begin
         term_ff <= a_sum[64:1];
      end
   end

   assign term      = term_ff;
   assign value_out = neg_ff ? -$signed(mag_ff) : $signed(mag_ff);

endmodule

`default_nettype wire

// ----- src/abfdu_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abfdu_merge: energy merge
// Sums the lane energy terms over a registered tree and adds them to the
// saturating energy total.
// ----------------------------------------------------------------------------
`default_nettype none

module abfdu_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire abfdu_pkg::merge_ctrl_type     ctrl,
   input  wire logic [abfdu_pkg::TERM_W-1:0]  terms [abfdu_pkg::NUM_LANES],
   output logic [abfdu_pkg::ENERGY_W-1:0]     total,
   output logic                               overflow
);

   localparam logic [abfdu_pkg::SUM_W-1:0] ENERGY_MAX =
      abfdu_pkg::SUM_W'({abfdu_pkg::ENERGY_W{1'b1}});

   logic [abfdu_pkg::PAIR_W-1:0]   pair_ff [3];
   logic [abfdu_pkg::SUM_W-1:0]    sum_ff;
   logic [abfdu_pkg::ENERGY_W-1:0] total_ff, total_in;
   logic                           ovf_ff, ovf_in;
   logic [abfdu_pkg::SUM_W-1:0]    acc;

   always_comb begin
      acc      = sum_ff + abfdu_pkg::SUM_W'(total_ff);
      total_in = total_ff;
      ovf_in   = ovf_ff;
      if (ctrl.clear) begin
         total_in = '0;
         ovf_in   = 1'b0;
      end else if (ctrl.acc_en) begin
         if (acc > ENERGY_MAX) begin
            total_in = ENERGY_MAX[abfdu_pkg::ENERGY_W-1:0];
            ovf_in   = 1'b1;
         end else begin
            total_in = acc[abfdu_pkg::ENERGY_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
      end
      if (ctrl.pair_en) begin
         for (int i = 0; i < 3; i++) begin
            pair_ff[i] <= abfdu_pkg::PAIR_W'(terms[2*i]) +
                          abfdu_pkg::PAIR_W'(terms[2*i+1]);
         end
      end
      if (ctrl.sum_en) begin
         sum_ff <= abfdu_pkg::SUM_W'(pair_ff[0]) + abfdu_pkg::SUM_W'(pair_ff[1]) +
                   abfdu_pkg::SUM_W'(pair_ff[2]);
      end
   end

   assign total    = total_ff;
   assign overflow = ovf_ff;

endmodule

`default_nettype wire

// ----- src/absorbing_boundary_field_damper_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// absorbing_boundary_field_damper_unit: absorbing layer field damper
// Damps the six field components of a grid node once for each damping
// slab that holds it and keeps a saturating total of energy removed.
// ----------------------------------------------------------------------------
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_payload_type
//   rsp      out        rsp_valid/rsp_stall  rsp_payload_type
//   csr      in         csr_we               csr_index, csr_wdata
//
// One node at a time; each slab holding it (0 to 6 of them) waits on the shared
// one-bit-per-cycle factor divider, then runs the lane and merge steps:
// square, multiply, update, pair sum, total sum and accumulate.
// Reset clears the widths, the energy total and the handshake state.
// The result waits in an output register while rsp_stall is high; the next
// node is taken meanwhile and holds in its final step until the beat leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module absorbing_boundary_field_damper_unit #(
   parameter int GRID_X = abfdu_pkg::GRID_DEFAULT,
   parameter int GRID_Y = abfdu_pkg::GRID_DEFAULT,
   parameter int GRID_Z = abfdu_pkg::GRID_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire abfdu_pkg::req_payload_type       req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output abfdu_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                             csr_we,
   input  wire logic [abfdu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [abfdu_pkg::CSR_W-1:0]      csr_wdata
);

   localparam logic [abfdu_pkg::CALC_W-1:0] MAX_X = abfdu_pkg::CALC_W'(GRID_X - 1);
   localparam logic [abfdu_pkg::CALC_W-1:0] MAX_Y = abfdu_pkg::CALC_W'(GRID_Y - 1);
   localparam logic [abfdu_pkg::CALC_W-1:0] MAX_Z = abfdu_pkg::CALC_W'(GRID_Z - 1);

   abfdu_pkg::state_type state_ff, state_in;

   logic [abfdu_pkg::CSR_W-1:0]      damp_ff [abfdu_pkg::NUM_SLABS];
   logic [abfdu_pkg::SLAB_IDX_W-1:0] slab_idx_ff, slab_idx_in;
   logic [abfdu_pkg::COORD_W-1:0]    x_ff, y_ff, z_ff;
   logic [abfdu_pkg::QUOT_W-1:0]     g_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   abfdu_pkg::rsp_payload_type       rsp_ff;

   logic                             req_accept;
   logic                             out_load;
   logic                             idx_clr, idx_inc, g_en, div_start;
   abfdu_pkg::lane_ctrl_type         lane_ctrl;
   abfdu_pkg::merge_ctrl_type        merge_ctrl;

   logic [abfdu_pkg::CALC_W-1:0]     p, w, maxp, d_full;
   logic                             high, in_grid, slab_hit, at_end;
   logic [abfdu_pkg::CSR_W-1:0]      d;
   logic [17:0]                      w2;
   logic [17:0]                      d2;
   logic [abfdu_pkg::DIV_W-1:0]      div_num, div_den;
   logic                             div_busy;
   logic [abfdu_pkg::QUOT_W-1:0]     fq;
   logic [63:0]                      fsq;
   logic [32:0]                      g_full;

   logic signed [31:0]               lane_in  [abfdu_pkg::NUM_LANES];
   logic signed [31:0]               lane_out [abfdu_pkg::NUM_LANES];
   logic [abfdu_pkg::TERM_W-1:0]     terms    [abfdu_pkg::NUM_LANES];
   logic [abfdu_pkg::ENERGY_W-1:0]   energy_total;
   logic                             energy_ovf;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != abfdu_pkg::ST_IDLE;
   assign at_end     = slab_idx_ff == abfdu_pkg::SLAB_END;
   assign out_load   = (state_ff == abfdu_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < abfdu_pkg::NUM_SLABS; i++) begin
            damp_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            abfdu_pkg::CSR_DAMP_LOW_X:  damp_ff[0] <= csr_wdata;
            abfdu_pkg::CSR_DAMP_HIGH_X: damp_ff[1] <= csr_wdata;
            abfdu_pkg::CSR_DAMP_LOW_Y:  damp_ff[2] <= csr_wdata;
            abfdu_pkg::CSR_DAMP_HIGH_Y: damp_ff[3] <= csr_wdata;
            abfdu_pkg::CSR_DAMP_LOW_Z:  damp_ff[4] <= csr_wdata;
            abfdu_pkg::CSR_DAMP_HIGH_Z: damp_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // slab select
   always_comb begin
      p    = '0;
      w    = '0;
      maxp = '0;
      high = 1'b0;
      case (slab_idx_ff)
         abfdu_pkg::SLAB_X_LOW: begin
            p = abfdu_pkg::CALC_W'(x_ff); w = abfdu_pkg::CALC_W'(damp_ff[0]); maxp = MAX_X;
         end
         abfdu_pkg::SLAB_X_HIGH: begin
            p = abfdu_pkg::CALC_W'(x_ff); w = abfdu_pkg::CALC_W'(damp_ff[1]); maxp = MAX_X;
            high = 1'b1;
         end
         abfdu_pkg::SLAB_Y_HIGH: begin
            p = abfdu_pkg::CALC_W'(y_ff); w = abfdu_pkg::CALC_W'(damp_ff[3]); maxp = MAX_Y;
            high = 1'b1;
         end
         abfdu_pkg::SLAB_Y_LOW: begin
            p = abfdu_pkg::CALC_W'(y_ff); w = abfdu_pkg::CALC_W'(damp_ff[2]); maxp = MAX_Y;
         end
         abfdu_pkg::SLAB_Z_HIGH: begin
            p = abfdu_pkg::CALC_W'(z_ff); w = abfdu_pkg::CALC_W'(damp_ff[5]); maxp = MAX_Z;
            high = 1'b1;
         end
         abfdu_pkg::SLAB_Z_LOW: begin
            p = abfdu_pkg::CALC_W'(z_ff); w = abfdu_pkg::CALC_W'(damp_ff[4]); maxp = MAX_Z;
         end
         default: ;
      endcase
      in_grid  = (abfdu_pkg::CALC_W'(x_ff) <= MAX_X) && (abfdu_pkg::CALC_W'(y_ff) <= MAX_Y)
                 && (abfdu_pkg::CALC_W'(z_ff) <= MAX_Z);
      slab_hit = in_grid && (w != '0) && (high ? (p + w > maxp) : (p < w));
      d_full   = maxp - p;
      d        = high ? d_full[abfdu_pkg::CSR_W-1:0] : p[abfdu_pkg::CSR_W-1:0];
      w2       = 18'(w) * 18'(w);
      d2       = 18'(d) * 18'(d);
      div_num  = (abfdu_pkg::DIV_W'(w2) << 2) + abfdu_pkg::DIV_W'(d2);
      div_den  = (abfdu_pkg::DIV_W'(w2) << 2) + abfdu_pkg::DIV_W'(w2);
      fsq      = 64'(fq) * 64'(fq);
      g_full   = 33'h1_0000_0000 - 33'(fsq[63:32]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         abfdu_pkg::ST_IDLE: if (req_accept) state_in = abfdu_pkg::ST_SEL;
         abfdu_pkg::ST_SEL: begin
            if (at_end) begin
               state_in = abfdu_pkg::ST_DONE;
            end else if (slab_hit) begin
               state_in = abfdu_pkg::ST_DIV;
            end
         end
         abfdu_pkg::ST_DIV:  if (!div_busy) state_in = abfdu_pkg::ST_SQ;
         abfdu_pkg::ST_SQ:   state_in = abfdu_pkg::ST_MUL;
         abfdu_pkg::ST_MUL:  state_in = abfdu_pkg::ST_UPD;
         abfdu_pkg::ST_UPD:  state_in = abfdu_pkg::ST_SUM;
         abfdu_pkg::ST_SUM:  state_in = abfdu_pkg::ST_SUM2;
         abfdu_pkg::ST_SUM2: state_in = abfdu_pkg::ST_ACC;
         abfdu_pkg::ST_ACC:  state_in = abfdu_pkg::ST_SEL;
         abfdu_pkg::ST_DONE: if (out_load) state_in = abfdu_pkg::ST_IDLE;
         default:            state_in = abfdu_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      lane_ctrl  = '0;
      merge_ctrl = '0;
      idx_clr    = 1'b0;
      idx_inc    = 1'b0;
      g_en       = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         abfdu_pkg::ST_IDLE: begin
            lane_ctrl.load   = req_accept;
            merge_ctrl.clear = req_accept && req_payload.clear_energy;
            idx_clr          = req_accept;
         end
         abfdu_pkg::ST_SEL: begin
            div_start = !at_end && slab_hit;
            idx_inc   = !at_end && !slab_hit;
         end
         abfdu_pkg::ST_SQ: begin
            lane_ctrl.sq_en = 1'b1;
            g_en            = 1'b1;
         end
         abfdu_pkg::ST_MUL:  lane_ctrl.mul_en = 1'b1;
         abfdu_pkg::ST_UPD:  lane_ctrl.upd_en = 1'b1;
         abfdu_pkg::ST_SUM:  merge_ctrl.pair_en = 1'b1;
         abfdu_pkg::ST_SUM2: merge_ctrl.sum_en = 1'b1;
         abfdu_pkg::ST_ACC: begin
            merge_ctrl.acc_en = 1'b1;
            idx_inc           = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      slab_idx_in = slab_idx_ff;
      if (idx_clr) begin
         slab_idx_in = '0;
      end else if (idx_inc) begin
         slab_idx_in = slab_idx_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= abfdu_pkg::ST_IDLE;
         slab_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slab_idx_ff  <= slab_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         x_ff <= req_payload.node_x;
         y_ff <= req_payload.node_y;
         z_ff <= req_payload.node_z;
      end
      if (g_en) begin
         g_ff <= g_full[abfdu_pkg::QUOT_W-1:0];
      end
      if (out_load) begin
         rsp_ff.ex_out           <= lane_out[0];
         rsp_ff.ey_out           <= lane_out[1];
         rsp_ff.ez_out           <= lane_out[2];
         rsp_ff.bx_out           <= lane_out[3];
         rsp_ff.by_out           <= lane_out[4];
         rsp_ff.bz_out           <= lane_out[5];
         rsp_ff.energy_removed   <= energy_total;
         rsp_ff.energy_saturated <= energy_ovf;
      end
   end

   assign lane_in[0] = req_payload.ex_in;
   assign lane_in[1] = req_payload.ey_in;
   assign lane_in[2] = req_payload.ez_in;
   assign lane_in[3] = req_payload.bx_in;
   assign lane_in[4] = req_payload.by_in;
   assign lane_in[5] = req_payload.bz_in;

   abfdu_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (fq)
   );

   for (genvar i = 0; i < abfdu_pkg::NUM_LANES; i++) begin : g_lane
      abfdu_lane u_lane (
         .clock     (clock),
         .ctrl      (lane_ctrl),
         .value_in  (lane_in[i]),
         .fq        (fq),
         .g         (g_ff),
         .term      (terms[i]),
         .value_out (lane_out[i])
      );
   end

   abfdu_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (merge_ctrl),
      .terms    (terms),
      .total    (energy_total),
      .overflow (energy_ovf)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_sat_at_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.energy_saturated |-> &rsp_ff.energy_removed)
      else $error("saturated energy below maximum");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == abfdu_pkg::ST_SQ |-> !div_busy)
      else $error("factor used while divider busy");

   a_slab_range: assert property (@(posedge clock) disable iff (reset)
      state_ff != abfdu_pkg::ST_IDLE |-> slab_idx_ff <= abfdu_pkg::SLAB_END)
      else $error("slab index out of range");

endmodule

`default_nettype wire
